[hdl/mrq_pkg.sv]
// Shared types, codes and constants for the min-priority ready queue.
package mrq_pkg;

  // Default number of entries the queue holds
  localparam int unsigned QueueDepthDef = 16;

  // Field widths
  localparam int unsigned IdW   = 16;
  localparam int unsigned PrioW = 8;
  localparam int unsigned OccW  = 5;

  // Operation codes
  localparam logic OpEnq = 1'b0;
  localparam logic OpDeq = 1'b1;

  // Result status codes
  localparam logic [1:0] StDone  = 2'd0;
  localparam logic [1:0] StFull  = 2'd1;
  localparam logic [1:0] StEmpty = 2'd2;

  // One stored entry
  typedef struct packed {
    logic [PrioW-1:0] prio;
    logic [IdW-1:0]   id;
  } entry_t;

  // Controller states
  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_SCAN_END,
    S_SHIFT,
    S_SHIFT_END,
    S_DONE
  } state_e;

  // Commands from controller to datapath
  typedef struct packed {
    logic       accept;      // beat taken: load result status, clear result payload
    logic [1:0] res_status;  // status recorded on accept
    logic       enq_wr;      // append input entry at the tail
    logic       scan_init;   // restart scan pointer at the head
    logic       scan_rd;     // read entry at scan pointer, advance
    logic       shift_init;  // point at the winning entry
    logic       shift_rd;    // read the entry behind the pointer, advance
    logic       take;        // drop one entry, latch the winner as result
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic full;
    logic empty;
    logic scan_last;   // scan pointer sits on the last held entry
    logic shift_more;  // an entry still lies behind the shift pointer
  } stat_t;

endpackage

[hdl/min_priority_ready_queue.sv]
// Top level of the bounded, stable min-priority ready queue.
// Enqueue and any rejected or empty operation: result strobe in the cycle after start,
//   next start taken once the controller is back in idle after the strobe.
// Dequeue: a scan of every held entry, then a close-up behind the winner, then the strobe;
//   scan and close-up run one after the other on the single read port of the entry memory.
// Reset clears the controller and the fill count; entry contents are left as they are.
// Each result is presented for one cycle on done_o; the receiver cannot stall it.
module min_priority_ready_queue
  import mrq_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = QueueDepthDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  output logic             busy_o,
  input  logic             op_i,
  input  logic [IdW-1:0]   proc_id_i,
  input  logic [PrioW-1:0] priority_req_i,
  output logic             done_o,
  output logic [1:0]       status_o,
  output logic [IdW-1:0]   out_id_o,
  output logic [PrioW-1:0] out_priority_o,
  output logic [OccW-1:0]  occupancy_o,
  output logic             is_empty_o
);

  cmd_t  cmd;
  stat_t stat;

  // Sequencer
  mrq_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .op_i    (op_i),
    .stat_i  (stat),
    .cmd_o   (cmd),
    .busy_o  (busy_o),
    .done_o  (done_o)
  );

  // Storage and compare
  mrq_datapath #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .proc_id_i      (proc_id_i),
    .priority_req_i (priority_req_i),
    .stat_o         (stat),
    .status_o       (status_o),
    .out_id_o       (out_id_o),
    .out_priority_o (out_priority_o),
    .occupancy_o    (occupancy_o),
    .is_empty_o     (is_empty_o)
  );

endmodule

[hdl/mrq_ctrl.sv]
// Sequencing controller for the min-priority ready queue.
module mrq_ctrl
  import mrq_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  start_i,
  input  logic  op_i,
  input  stat_t stat_i,
  output cmd_t  cmd_o,
  output logic  busy_o,
  output logic  done_o
);

  state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.res_status = StDone;
    busy_o  = 1'b1;
    done_o  = 1'b0;
    case (state_q)
      S_IDLE: begin
        busy_o = 1'b0;
        if (start_i) begin
          cmd_o.accept = 1'b1;
          if (op_i == OpEnq) begin
            if (stat_i.full) begin
              cmd_o.res_status = StFull;
            end else begin
              cmd_o.enq_wr = 1'b1;
            end
            state_d = S_DONE;
          end else if (stat_i.empty) begin
            cmd_o.res_status = StEmpty;
            state_d = S_DONE;
          end else begin
            cmd_o.scan_init = 1'b1;
            state_d = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        cmd_o.scan_rd = 1'b1;
        if (stat_i.scan_last) begin
          state_d = S_SCAN_END;
        end
      end
      S_SCAN_END: begin
        // last compare lands this cycle
        cmd_o.shift_init = 1'b1;
        state_d = S_SHIFT;
      end
      S_SHIFT: begin
        if (stat_i.shift_more) begin
          cmd_o.shift_rd = 1'b1;
        end else begin
          state_d = S_SHIFT_END;
        end
      end
      S_SHIFT_END: begin
        // final close-up write has already landed in the last shift state
        cmd_o.take = 1'b1;
        state_d = S_DONE;
      end
      S_DONE: begin
        done_o  = 1'b1;
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

[hdl/mrq_datapath.sv]
// Entry memory, fill count, minimum scan and close-up shift datapath.
module mrq_datapath
  import mrq_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = QueueDepthDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cmd_t             cmd_i,
  input  logic [IdW-1:0]   proc_id_i,
  input  logic [PrioW-1:0] priority_req_i,
  output stat_t            stat_o,
  output logic [1:0]       status_o,
  output logic [IdW-1:0]   out_id_o,
  output logic [PrioW-1:0] out_priority_o,
  output logic [OccW-1:0]  occupancy_o,
  output logic             is_empty_o
);

  localparam int unsigned AW    = $clog2(QUEUE_DEPTH);
  localparam int unsigned FillW = $clog2(QUEUE_DEPTH + 1);

  localparam logic [FillW-1:0] DepthVal = FillW'(QUEUE_DEPTH);
  localparam logic [FillW-1:0] One      = FillW'(1);

  entry_t mem [QUEUE_DEPTH];

  logic [FillW-1:0] fill_q;
  logic [FillW-1:0] ptr_q;
  logic [FillW-1:0] ptr_next;
  logic [AW-1:0]    rd_addr;
  logic             rd_en;
  entry_t           rdata_q;

  logic             rdv_q, shv_q;
  logic [AW-1:0]    rd_idx_q;
  logic [AW-1:0]    wr_idx_q;

  logic [AW-1:0]    best_idx_q, best_idx_d;
  entry_t           best_q, best_d;

  logic [1:0]       res_status_q;
  entry_t           res_q;

  assign ptr_next = ptr_q + One;

  // Status toward the controller
  assign stat_o.full       = (fill_q == DepthVal);
  assign stat_o.empty      = (fill_q == '0);
  assign stat_o.scan_last  = (ptr_next == fill_q);
  assign stat_o.shift_more = (ptr_next < fill_q);

  // Single read port: scan reads the pointer, shift reads the entry behind it
  assign rd_en   = cmd_i.scan_rd | cmd_i.shift_rd;
  assign rd_addr = cmd_i.scan_rd ? ptr_q[AW-1:0] : ptr_next[AW-1:0];

  // Entry memory: tail append or close-up write; registered read
  always_ff @(posedge clk_i) begin
    if (cmd_i.enq_wr) begin
      mem[fill_q[AW-1:0]] <= '{prio: priority_req_i, id: proc_id_i};
    end else if (shv_q) begin
      mem[wr_idx_q] <= rdata_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rdata_q <= mem[rd_addr];
    end
  end

  // Read-pipeline tags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rdv_q <= 1'b0;
      shv_q <= 1'b0;
    end else begin
      rdv_q <= cmd_i.scan_rd;
      shv_q <= cmd_i.shift_rd;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_idx_q <= ptr_q[AW-1:0];
    wr_idx_q <= ptr_q[AW-1:0];
  end

  // Running minimum: strict less-than keeps the earliest arrival on ties
  always_comb begin
    best_idx_d = best_idx_q;
    best_d     = best_q;
    if (rdv_q && ((rd_idx_q == '0) || (rdata_q.prio < best_q.prio))) begin
      best_idx_d = rd_idx_q;
      best_d     = rdata_q;
    end
  end

  always_ff @(posedge clk_i) begin
    best_idx_q <= best_idx_d;
    best_q     <= best_d;
  end

  // Scan / shift pointer
  always_ff @(posedge clk_i) begin
    if (cmd_i.scan_init) begin
      ptr_q <= '0;
    end else if (cmd_i.shift_init) begin
      ptr_q <= FillW'(best_idx_d);
    end else if (rd_en) begin
      ptr_q <= ptr_next;
    end
  end

  // Fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
    end else if (cmd_i.enq_wr) begin
      fill_q <= fill_q + One;
    end else if (cmd_i.take) begin
      fill_q <= fill_q - One;
    end
  end

  // Result registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      res_status_q <= cmd_i.res_status;
      res_q        <= '0;
    end else if (cmd_i.take) begin
      res_q        <= best_q;
    end
  end

  assign status_o       = res_status_q;
  assign out_id_o       = res_q.id;
  assign out_priority_o = res_q.prio;
  assign occupancy_o    = OccW'(fill_q);
  assign is_empty_o     = (fill_q == '0);

endmodule

[bench/mrq_checker.sv]
// Checker for the min-priority ready queue: predicts each result and compares it.
`timescale 1ns / 100ps

module mrq_checker
  import mrq_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = QueueDepthDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic             busy_i,
  input  logic             op_i,
  input  logic [IdW-1:0]   proc_id_i,
  input  logic [PrioW-1:0] priority_req_i,
  input  logic             done_i,
  input  logic [1:0]       status_i,
  input  logic [IdW-1:0]   out_id_i,
  input  logic [PrioW-1:0] out_priority_i,
  input  logic [OccW-1:0]  occupancy_i,
  input  logic             is_empty_i,
  output int unsigned      fail_count_o,
  output int unsigned      awaited_o,
  output int unsigned      checked_o,
  output int unsigned      rejected_o,
  output int unsigned      drained_o,
  output int unsigned      deepest_o
);

  // One predicted result beat
  typedef struct packed {
    logic [1:0]       status;
    logic [IdW-1:0]   id;
    logic [PrioW-1:0] prio;
    logic [OccW-1:0]  occ;
    logic             empty;
  } sched_outcome_t;

  // Predicted queue contents, arrival order from index 0
  logic [IdW-1:0]   held_ids   [QUEUE_DEPTH];
  logic [PrioW-1:0] held_prios [QUEUE_DEPTH];
  int unsigned      held;

  sched_outcome_t   awaited_outcomes[$];
  int unsigned      fails, checked, rejected, drained, deepest;

  // Print one line per mismatch (capped) and count it
  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    if (fails < 40)
      $display("[%0t] mismatch: %s got %0h expected %0h", $realtime, what, got, want);
    fails++;
  endtask

  // Apply one operation to the predicted queue and work out its result
  task automatic model_queue_op(input logic op, input logic [IdW-1:0] id,
                                input logic [PrioW-1:0] pr, output sched_outcome_t res);
    int unsigned best;
    res = '0;
    res.status = StDone;
    if (op == OpEnq) begin
      if (held >= QUEUE_DEPTH) begin
        res.status = StFull;
      end else begin
        held_ids[held]   = id;
        held_prios[held] = pr;
        held++;
      end
    end else if (held == 0) begin
      res.status = StEmpty;
    end else begin
      // lowest priority wins, earliest arrival on ties
      best = 0;
      for (int unsigned i = 1; i < held; i++)
        if (held_prios[i] < held_prios[best]) best = i;
      res.id   = held_ids[best];
      res.prio = held_prios[best];
      // close up behind the winner
      for (int unsigned i = best; i + 1 < held; i++) begin
        held_ids[i]   = held_ids[i+1];
        held_prios[i] = held_prios[i+1];
      end
      held--;
    end
    res.occ   = held[OccW-1:0];
    res.empty = (held == 0);
  endtask

  // Compare result beats, then predict accepted requests
  always @(posedge clk_i or negedge rst_ni) begin
    sched_outcome_t want, fresh;
    if (!rst_ni) begin
      held = 0;
      awaited_outcomes.delete();
      fails = 0; checked = 0; rejected = 0; drained = 0; deepest = 0;
    end else begin
      if (done_i) begin
        if (awaited_outcomes.size() == 0) begin
          report_mismatch("result with none awaited, status", status_i, 0);
        end else begin
          want = awaited_outcomes.pop_front();
          checked++;
          if (status_i != want.status)
            report_mismatch("status", status_i, want.status);
          if (out_id_i != want.id)
            report_mismatch("out_id", out_id_i, want.id);
          if (out_priority_i != want.prio)
            report_mismatch("out_priority", out_priority_i, want.prio);
          if (occupancy_i != want.occ)
            report_mismatch("occupancy", occupancy_i, want.occ);
          if (is_empty_i != want.empty)
            report_mismatch("is_empty", is_empty_i, want.empty);
        end
      end
      if (start_i && !busy_i) begin
        model_queue_op(op_i, proc_id_i, priority_req_i, fresh);
        awaited_outcomes.push_back(fresh);
        if (fresh.status == StFull) rejected++;
        if (fresh.status == StEmpty) drained++;
        if (held > deepest) deepest = held;
      end
    end
    fail_count_o <= fails;
    awaited_o    <= awaited_outcomes.size();
    checked_o    <= checked;
    rejected_o   <= rejected;
    drained_o    <= drained;
    deepest_o    <= deepest;
  end

endmodule

[bench/tb_min_priority_ready_queue.sv]
// Testbench top for the min-priority ready queue: stimulus, timeout and verdict.
`timescale 1ns / 100ps

module tb_min_priority_ready_queue
  import mrq_pkg::*;
();

  localparam int unsigned Depth        = QueueDepthDef;
  localparam int unsigned SettleCycles = 2 * Depth + 16;
  localparam int unsigned CycleLimit   = 400000;
  localparam int unsigned RandBlocks   = 21;
  localparam int unsigned BlockItems   = 50;

  logic             clk_i;
  logic             rst_ni;
  logic             start_i;
  logic             busy_o;
  logic             op_i;
  logic [IdW-1:0]   proc_id_i;
  logic [PrioW-1:0] priority_req_i;
  logic             done_o;
  logic [1:0]       status_o;
  logic [IdW-1:0]   out_id_o;
  logic [PrioW-1:0] out_priority_o;
  logic [OccW-1:0]  occupancy_o;
  logic             is_empty_o;

  int unsigned fail_count, awaited, checked, rejected, drained, deepest;
  int unsigned cycle_cnt;
  logic        calm;  // no gaps between requests while set

  min_priority_ready_queue #(.QUEUE_DEPTH(Depth)) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .op_i           (op_i),
    .proc_id_i      (proc_id_i),
    .priority_req_i (priority_req_i),
    .done_o         (done_o),
    .status_o       (status_o),
    .out_id_o       (out_id_o),
    .out_priority_o (out_priority_o),
    .occupancy_o    (occupancy_o),
    .is_empty_o     (is_empty_o)
  );

  mrq_checker #(.QUEUE_DEPTH(Depth)) u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_i         (busy_o),
    .op_i           (op_i),
    .proc_id_i      (proc_id_i),
    .priority_req_i (priority_req_i),
    .done_i         (done_o),
    .status_i       (status_o),
    .out_id_i       (out_id_o),
    .out_priority_i (out_priority_o),
    .occupancy_i    (occupancy_o),
    .is_empty_i     (is_empty_o),
    .fail_count_o   (fail_count),
    .awaited_o      (awaited),
    .checked_o      (checked),
    .rejected_o     (rejected),
    .drained_o      (drained),
    .deepest_o      (deepest)
  );

  // 12 ns clock
  always begin
    clk_i = 1'b1;
    #6;
    clk_i = 1'b0;
    #6;
  end

  // Run limit
  initial cycle_cnt = 0;
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CycleLimit) begin
      $display("timeout after %0d cycles, %0d results still awaited", cycle_cnt, awaited);
      $display("== FAIL ==");
      $finish;
    end
  end

  // Present one request after a random gap and hold it until the beat is taken
  task automatic issue_request(input logic op, input logic [IdW-1:0] id,
                               input logic [PrioW-1:0] pr);
    int unsigned gap;
    gap = calm ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start_i        <= 1'b1;
    op_i           <= op;
    proc_id_i      <= id;
    priority_req_i <= pr;
    do @(posedge clk_i); while (busy_o);
  endtask

  // Priorities: narrow band for ties, full range, and the extremes
  function automatic logic [PrioW-1:0] draw_prio();
    int unsigned pick;
    pick = $urandom_range(0, 9);
    if (pick < 4) return PrioW'($urandom_range(60, 63));
    if (pick == 4) return '0;
    if (pick == 5) return '1;
    return PrioW'($urandom_range(0, 255));
  endfunction

  initial begin
    int unsigned enq_pct;
    logic [IdW-1:0]   id;
    logic [PrioW-1:0] pr;
    rst_ni         = 1'b0;
    start_i        = 1'b0;
    op_i           = OpEnq;
    proc_id_i      = '0;
    priority_req_i = '0;
    calm           = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: dequeue on empty queue, fields set to ignored extremes
    issue_request(OpDeq, '1, '1);
    // Fill to depth with extreme ids and tied priorities (zero and 0x40 twice each)
    for (int unsigned i = 0; i < Depth; i++) begin
      if (i == 0) id = '0;
      else if (i == Depth - 1) id = '1;
      else id = {4'(i), 4'hA, 8'(i * 17)};
      case (i)
        0:       pr = '1;
        1, 12:   pr = 8'h40;
        6, 9:    pr = '0;
        default: pr = 8'h80 + 8'(i);
      endcase
      issue_request(OpEnq, id, pr);
    end
    // Enqueue on a full queue is rejected
    issue_request(OpEnq, '1, '0);
    // Dequeues walk through the ties in arrival order
    repeat (6) issue_request(OpDeq, 16'h0F0F, 8'hF0);

    // Random: blocks with different enqueue mix to sweep full and empty
    for (int unsigned b = 0; b < RandBlocks; b++) begin
      case ($urandom_range(0, 3))
        0:       enq_pct = 25;
        1:       enq_pct = 50;
        2:       enq_pct = 70;
        default: enq_pct = 90;
      endcase
      calm = ($urandom_range(0, 3) == 0);
      for (int unsigned k = 0; k < BlockItems; k++) begin
        if ($urandom_range(0, 99) < enq_pct)
          issue_request(OpEnq, IdW'($urandom_range(0, 65535)), draw_prio());
        else
          issue_request(OpDeq, IdW'($urandom_range(0, 65535)), PrioW'($urandom_range(0, 255)));
      end
    end
    start_i <= 1'b0;

    // Drain, then allow for a late stray beat
    @(posedge clk_i);
    while (awaited != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);

    $display("checked %0d results: %0d enqueues rejected on full, %0d dequeues on empty,",
             checked, rejected, drained);
    $display("queue reached %0d of %0d entries; %0d mismatches, %0d results missing",
             deepest, Depth, fail_count, awaited);
    if (fail_count == 0 && awaited == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
